// ===== hw/rtl/jhd_pkg.sv =====
// shared types and constants for the jpeg huffman decoder
package jhd_pkg;

   localparam int MAX_CODE_LEN_DEF = 16;
   localparam int SYMBOL_DEPTH_DEF = 256;

   localparam int NUM_LENGTHS = 16;
   localparam int LEN_IDX_W = 4;
   localparam int EXPECT_W = 10;
   localparam int INDEX_W = 10;
   localparam int FIRST_CODE_W = 17;
   localparam int FIRST_INDEX_W = 9;

   localparam logic [4:0] COUNTS_END = 5'd17;
   localparam logic [LEN_IDX_W-1:0] LAST_LEN_IDX = 4'd15;
   localparam logic [EXPECT_W-1:0] EXPECT_SAT = 10'd1023;

   localparam logic [7:0] BYTE_MARKER = 8'hFF;
   localparam logic [7:0] BYTE_STUFF = 8'h00;

   // request function codes
   localparam logic [1:0] FUNC_TABLE = 2'd0;
   localparam logic [1:0] FUNC_DATA = 2'd1;
   localparam logic [1:0] FUNC_NEW_TABLE = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BAD_CODE = 2'd1;
   localparam logic [1:0] STATUS_NO_TABLE = 2'd2;

   typedef struct packed {
      logic       clear;
      logic       count_wr;
      logic [7:0] count_byte;
   } jhd_tbl_cmd_type;

   typedef struct packed {
      logic                busy;
      logic                complete;
      logic                ok;
      logic [EXPECT_W-1:0] expected;
   } jhd_tbl_stat_type;

   typedef struct packed {
      logic               match;
      logic [INDEX_W-1:0] index;
   } jhd_look_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic [4:0] code_length;
      logic [1:0] status;
   } jhd_result_type;

endpackage

// ===== hw/rtl/jhd_if.sv =====
// request and response channel interfaces
interface jhd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface jhd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic [4:0] code_length;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output symbol, output code_length, output status,
                   output last, input ready);
   modport sink (input valid, input symbol, input code_length, input status,
                 input last, output ready);
endinterface

// ===== hw/rtl/jhd_code_table.sv =====
// per-length code counts, canonical table builder and code lookup
module jhd_code_table #(
   parameter int MAX_CODE_LEN = jhd_pkg::MAX_CODE_LEN_DEF,
   parameter int SYMBOL_DEPTH = jhd_pkg::SYMBOL_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  jhd_pkg::jhd_tbl_cmd_type            cmd,
   output jhd_pkg::jhd_tbl_stat_type           stat,
   input  logic [MAX_CODE_LEN-1:0]             look_code,
   input  logic [jhd_pkg::LEN_IDX_W-1:0]       look_len_idx,
   output jhd_pkg::jhd_look_type               look
);
   import jhd_pkg::*;

   logic [7:0]               count_ff [NUM_LENGTHS];
   logic [FIRST_CODE_W-1:0]  first_code_ff [NUM_LENGTHS];
   logic [FIRST_INDEX_W-1:0] first_index_ff [NUM_LENGTHS];

   logic [4:0]               load_pos_ff, load_pos_in;
   logic [EXPECT_W-1:0]      expected_ff, expected_in;
   logic                     busy_ff, busy_in;
   logic [LEN_IDX_W-1:0]     blen_ff, blen_in;
   logic [17:0]              code_ff, code_in;
   logic [FIRST_INDEX_W-1:0] idx_ff, idx_in;
   logic                     ok_ff, ok_in;
   logic                     complete_ff, complete_in;

   logic                     cnt_we;
   logic [LEN_IDX_W-1:0]     cnt_widx;
   logic [7:0]               n_cur;
   logic [18:0]              sum;
   logic [18:0]              limit;
   logic                     len_over;
   logic                     bad_step;
   logic [10:0]              expected_sum;
   logic [FIRST_CODE_W-1:0]  code_sat;

   logic [7:0]               look_cnt;
   logic [FIRST_CODE_W-1:0]  look_fc;
   logic [FIRST_INDEX_W-1:0] look_fi;
   logic [17:0]              look_diff;

   // one length per cycle through the shared adder
   always_comb begin
      n_cur = count_ff[blen_ff];
      sum = 19'(code_ff) + 19'(n_cur);
      limit = 19'd2 << blen_ff;
      len_over = (5'(blen_ff) + 5'd1) > 5'(MAX_CODE_LEN);
      bad_step = (len_over && (n_cur != 8'd0)) || (sum > limit);
      code_sat = (sum > 19'h1FFFF) ? 17'h1FFFF : sum[16:0];
      expected_sum = 11'(expected_ff) + 11'(cmd.count_byte);
      cnt_widx = 4'(load_pos_ff - 5'd1);
   end

   always_comb begin
      load_pos_in = load_pos_ff;
      expected_in = expected_ff;
      busy_in = busy_ff;
      blen_in = blen_ff;
      code_in = code_ff;
      idx_in = idx_ff;
      ok_in = ok_ff;
      complete_in = complete_ff;
      cnt_we = 1'b0;
      if (cmd.clear) begin
         load_pos_in = '0;
         expected_in = '0;
         busy_in = 1'b0;
         ok_in = 1'b0;
         complete_in = 1'b0;
      end else if (busy_ff) begin
         blen_in = blen_ff + 1'b1;
         code_in = {code_sat, 1'b0};
         idx_in = idx_ff + FIRST_INDEX_W'(n_cur);
         ok_in = ok_ff && !bad_step;
         if (blen_ff == LAST_LEN_IDX) begin
            busy_in = 1'b0;
            complete_in = 1'b1;
            if (expected_ff > EXPECT_W'(SYMBOL_DEPTH)) begin
               ok_in = 1'b0;
            end
         end
      end else if (cmd.count_wr && (load_pos_ff < COUNTS_END)) begin
         if (load_pos_ff != 5'd0) begin
            cnt_we = 1'b1;
            expected_in = (expected_sum > 11'(EXPECT_SAT)) ? EXPECT_SAT
                                                            : expected_sum[EXPECT_W-1:0];
         end
         load_pos_in = load_pos_ff + 5'd1;
         if (load_pos_ff == COUNTS_END - 5'd1) begin
            busy_in = 1'b1;
            blen_in = '0;
            code_in = '0;
            idx_in = '0;
            ok_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         expected_ff <= '0;
         busy_ff <= 1'b0;
         blen_ff <= '0;
         code_ff <= '0;
         idx_ff <= '0;
         ok_ff <= 1'b0;
         complete_ff <= 1'b0;
      end else begin
         load_pos_ff <= load_pos_in;
         expected_ff <= expected_in;
         busy_ff <= busy_in;
         blen_ff <= blen_in;
         code_ff <= code_in;
         idx_ff <= idx_in;
         ok_ff <= ok_in;
         complete_ff <= complete_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_ff[cnt_widx] <= cmd.count_byte;
      end
      if (busy_ff) begin
         first_code_ff[blen_ff] <= code_ff[FIRST_CODE_W-1:0];
         first_index_ff[blen_ff] <= idx_ff;
      end
   end

   // match when first_code <= code < first_code + count
   always_comb begin
      look_cnt = count_ff[look_len_idx];
      look_fc = first_code_ff[look_len_idx];
      look_fi = first_index_ff[look_len_idx];
      look_diff = 18'(look_code) - 18'(look_fc);
      look.match = !look_diff[17] && (look_diff[16:0] < 17'(look_cnt));
      look.index = INDEX_W'(look_fi) + INDEX_W'(look_diff[7:0]);
   end

   assign stat.busy = busy_ff;
   assign stat.complete = complete_ff;
   assign stat.ok = ok_ff;
   assign stat.expected = expected_ff;

endmodule

// ===== hw/rtl/jpeg_huffman_decoder_unit.sv =====
// data byte: accept, a bit step for each bit, an emit step per decoded code, then a flush
// table byte: taken in the idle state; the last count byte starts the table build
// data byte with no ready table: one status result
// one request in flight; a finished result waits in the output register
// reset clears control state and the table-ready flag; the symbol memory
// holds old contents and is only read at entries loaded for the current table
module jpeg_huffman_decoder_unit #(
   parameter int MAX_CODE_LEN = jhd_pkg::MAX_CODE_LEN_DEF,
   parameter int SYMBOL_DEPTH = jhd_pkg::SYMBOL_DEPTH_DEF
) (
   input logic       clock,
   input logic       reset,
   jhd_req_if.sink   req,
   jhd_rsp_if.source rsp
);
   import jhd_pkg::*;

   localparam int PL_W = $clog2(MAX_CODE_LEN + 1);
   localparam int AW = $clog2(SYMBOL_DEPTH);
   localparam int POS_W = $clog2(SYMBOL_DEPTH + 1);
   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_BIT   = 4'b0010,
      ST_EMIT  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [MAX_CODE_LEN-1:0] pc_ff, pc_in;
   logic [PL_W-1:0]   pl_ff, pl_in;
   logic              ff_seen_ff, ff_seen_in;
   logic              table_ready_ff, table_ready_in;
   logic [POS_W-1:0]  sym_pos_ff, sym_pos_in;
   logic [7:0]        shift_ff, shift_in;
   logic [2:0]        bit_cnt_ff, bit_cnt_in;
   jhd_result_type    res_ff, res_in;
   logic              res_oob_ff, res_oob_in;
   jhd_result_type    pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   jhd_result_type    out_ff, out_in;
   logic              out_last_ff, out_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        sym_q_ff;

   logic [7:0]        sym_mem [SYMBOL_DEPTH];

   jhd_tbl_cmd_type   tbl_cmd;
   jhd_tbl_stat_type  tbl_stat;
   jhd_look_type      look;

   logic                    req_acc;
   logic                    slot_free;
   logic [MAX_CODE_LEN-1:0] pc_new;
   logic [PL_W-1:0]         pl_new;
   logic                    mem_we;
   logic                    rd_en;
   logic                    look_oob;
   logic                    load_out;
   logic                    load_last;
   logic                    tbl_ready_now;
   jhd_result_type          emit_res;

   jhd_code_table #(
      .MAX_CODE_LEN(MAX_CODE_LEN),
      .SYMBOL_DEPTH(SYMBOL_DEPTH)
   ) u_code_table (
      .clock        (clock),
      .reset        (reset),
      .cmd          (tbl_cmd),
      .stat         (tbl_stat),
      .look_code    (pc_new),
      .look_len_idx (LEN_IDX_W'(pl_ff)),
      .look         (look)
   );

   assign req_acc = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign pc_new = {pc_ff[MAX_CODE_LEN-2:0], shift_ff[7]};
   assign pl_new = pl_ff + 1'b1;
   assign look_oob = look.index >= INDEX_W'(SYMBOL_DEPTH);
   // an empty valid table counts as ready in the first cycle after its build
   assign tbl_ready_now = table_ready_ff ||
                          (tbl_stat.complete && tbl_stat.ok && (tbl_stat.expected == '0));

   always_comb begin
      emit_res = res_ff;
      emit_res.symbol = ((res_ff.status == STATUS_OK) && !res_oob_ff) ? sym_q_ff : 8'h00;
   end

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      pl_in = pl_ff;
      ff_seen_in = ff_seen_ff;
      table_ready_in = table_ready_ff;
      sym_pos_in = sym_pos_ff;
      shift_in = shift_ff;
      bit_cnt_in = bit_cnt_ff;
      res_in = res_ff;
      res_oob_in = res_oob_ff;
      pend_in = pend_ff;
      pend_valid_in = pend_valid_ff;
      tbl_cmd.clear = 1'b0;
      tbl_cmd.count_wr = 1'b0;
      tbl_cmd.count_byte = req.data_byte;
      mem_we = 1'b0;
      rd_en = 1'b0;
      load_out = 1'b0;
      load_last = 1'b0;

      // a valid table with no symbols is ready once its build is complete
      if (tbl_stat.complete && tbl_stat.ok && (tbl_stat.expected == '0)) begin
         table_ready_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req.func)
                  FUNC_TABLE: begin
                     if (!tbl_stat.complete) begin
                        tbl_cmd.count_wr = 1'b1;
                     end else if (tbl_stat.ok && !tbl_ready_now) begin
                        mem_we = 1'b1;
                        sym_pos_in = sym_pos_ff + 1'b1;
                        if (EXPECT_W'(sym_pos_ff) + 1'b1 == tbl_stat.expected) begin
                           table_ready_in = 1'b1;
                        end
                     end
                  end
                  FUNC_DATA: begin
                     if (!tbl_ready_now) begin
                        pend_in.symbol = 8'h00;
                        pend_in.code_length = 5'd0;
                        pend_in.status = STATUS_NO_TABLE;
                        pend_valid_in = 1'b1;
                        state_in = ST_FLUSH;
                     end else if (ff_seen_ff && (req.data_byte == BYTE_STUFF)) begin
                        ff_seen_in = 1'b0;
                     end else begin
                        ff_seen_in = (req.data_byte == BYTE_MARKER);
                        shift_in = req.data_byte;
                        bit_cnt_in = '0;
                        state_in = ST_BIT;
                     end
                  end
                  FUNC_NEW_TABLE: begin
                     tbl_cmd.clear = 1'b1;
                     sym_pos_in = '0;
                     pc_in = '0;
                     pl_in = '0;
                     ff_seen_in = 1'b0;
                     table_ready_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_BIT: begin
            shift_in = {shift_ff[6:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (look.match) begin
               res_in.symbol = 8'h00;
               res_in.code_length = 5'(pl_new);
               res_in.status = STATUS_OK;
               res_oob_in = look_oob;
               rd_en = !look_oob;
               pc_in = '0;
               pl_in = '0;
               state_in = ST_EMIT;
            end else if (pl_new >= PL_W'(MAX_CODE_LEN)) begin
               res_in.symbol = 8'h00;
               res_in.code_length = 5'd0;
               res_in.status = STATUS_BAD_CODE;
               res_oob_in = 1'b0;
               pc_in = '0;
               pl_in = '0;
               state_in = ST_EMIT;
            end else begin
               pc_in = pc_new;
               pl_in = pl_new;
               if (bit_cnt_ff == LAST_BIT) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_EMIT: begin
            // hold the newest result back so the byte's last one can be marked
            if (!pend_valid_ff || slot_free) begin
               load_out = pend_valid_ff;
               pend_in = emit_res;
               pend_valid_in = 1'b1;
               state_in = (bit_cnt_ff == '0) ? ST_FLUSH : ST_BIT;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               load_out = 1'b1;
               load_last = 1'b1;
               pend_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_in = out_ff;
      out_last_in = out_last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         out_in = pend_ff;
         out_last_in = load_last;
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0;
         pl_ff <= '0;
         ff_seen_ff <= 1'b0;
         table_ready_ff <= 1'b0;
         sym_pos_ff <= '0;
         bit_cnt_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         pl_ff <= pl_in;
         ff_seen_ff <= ff_seen_in;
         table_ready_ff <= table_ready_in;
         sym_pos_ff <= sym_pos_in;
         bit_cnt_ff <= bit_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      res_ff <= res_in;
      res_oob_ff <= res_oob_in;
      pend_ff <= pend_in;
      out_ff <= out_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sym_mem[sym_pos_ff[AW-1:0]] <= req.data_byte;
      end
      if (rd_en) begin
         sym_q_ff <= sym_mem[look.index[AW-1:0]];
      end
   end

   assign req.ready = (state_ff == ST_IDLE) && !tbl_stat.busy;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.symbol = out_ff.symbol;
   assign rsp.code_length = out_ff.code_length;
   assign rsp.status = out_ff.status;
   assign rsp.last = out_last_ff;

`ifndef SYNTHESIS
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left behind in idle");

   a_build_not_ready: assert property (@(posedge clock) disable iff (reset)
      tbl_stat.busy |-> !table_ready_ff)
      else $error("table ready while build is running");

   a_ok_has_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_ff.status == STATUS_OK)) |-> (out_ff.code_length != 5'd0))
      else $error("decoded symbol with zero code length");

   a_error_no_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_ff.status != STATUS_OK))
         |-> ((out_ff.symbol == 8'h00) && (out_ff.code_length == 5'd0)))
      else $error("error result carries a symbol");
`endif

endmodule
